### rtl/pjt_pkg.sv
// ----------------------------------------------------------------------------
// pjt_pkg: shared types and constants for the job table
// Entry layout, transaction payloads, command and status codes, table sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package pjt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic [2:0] CMD_APPEND    = 3'd0;
	localparam logic [2:0] CMD_REMOVE    = 3'd1;
	localparam logic [2:0] CMD_FIND_JOB  = 3'd2;
	localparam logic [2:0] CMD_FIND_PROC = 3'd3;
	localparam logic [2:0] CMD_SET_STATE = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [15:0] job;
		logic [21:0] proc_id;
		logic [7:0]  state;
	} entry_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] job_id;
		logic [21:0] proc_id;
		logic [7:0]  new_state;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [15:0] out_job_id;
		logic [21:0] out_proc_id;
		logic [7:0]  out_state;
	} res_item_t;

	// table port request from the sequencer
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// finished result handed to the output register
	typedef struct packed {
		logic      done;
		res_item_t res;
	} done_t;

endpackage

`default_nettype wire

### rtl/pjt_store.sv
// ----------------------------------------------------------------------------
// pjt_store: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pjt_store (
	input  wire                    clk,
	input  wire pjt_pkg::mem_req_t req,
	output pjt_pkg::entry_t        rd
);
	import pjt_pkg::*;

	entry_t mem [ENTRIES];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	assign rd = rd_q;

endmodule

`default_nettype wire

### rtl/pjt_ctrl.sv
// ----------------------------------------------------------------------------
// pjt_ctrl: command sequencer
// Walks the table one entry per cycle through a single shared key comparator,
// then compacts the table after a removal, one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pjt_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     cmd_valid,
	output logic                    cmd_stall,
	input  wire pjt_pkg::cmd_item_t cmd_item,
	input  wire                     res_take,
	output pjt_pkg::done_t          done_o,
	output pjt_pkg::mem_req_t       req,
	input  wire pjt_pkg::entry_t    rd
);
	import pjt_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0]       state_q;
	cmd_item_t        cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	res_item_t        res_q;

	logic        accept;
	logic [21:0] cmp_a;
	logic [21:0] cmp_b;
	logic        hit;
	logic        by_job;
	logic        last;
	logic        shift_last;
	logic        full;
	entry_t      hit_entry;

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign full      = (count_q >= CNT_W'(ENTRIES));

	// shared comparator: job id or process id key
	assign by_job = (cmd_q.cmd == CMD_FIND_JOB) || (cmd_q.cmd == CMD_SET_STATE);
	assign cmp_a  = by_job ? {6'd0, rd.job} : rd.proc_id;
	assign cmp_b  = by_job ? {6'd0, cmd_q.job_id} : cmd_q.proc_id;
	assign hit    = (cmp_a == cmp_b);

	assign last       = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign shift_last = ((CNT_W'(idx_q) + CNT_W'(2)) == count_q);

	always_comb begin
		hit_entry = rd;
		if (cmd_q.cmd == CMD_SET_STATE) begin
			hit_entry.state = cmd_q.new_state;
		end
	end

	always_comb begin
		req       = '0;
		req.raddr = (state_q == S_IDLE) ? '0 : idx_q + IDX_W'(1);
		unique case (state_q)
			S_IDLE: begin
				if (accept && (cmd_item.cmd == CMD_APPEND) && !full) begin
					req.we            = 1'b1;
					req.waddr         = count_q[IDX_W-1:0];
					req.wdata.job     = cmd_item.job_id;
					req.wdata.proc_id = cmd_item.proc_id;
					req.wdata.state   = cmd_item.new_state;
				end
			end
			S_SEARCH: begin
				if (hit && (cmd_q.cmd == CMD_SET_STATE)) begin
					req.we    = 1'b1;
					req.waddr = idx_q;
					req.wdata = hit_entry;
				end
			end
			S_SHIFT: begin
				// read runs one entry ahead of the write: rd holds entry idx+1
				req.raddr = idx_q + IDX_W'(2);
				req.we    = 1'b1;
				req.waddr = idx_q;
				req.wdata = rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q <= cmd_item;
						idx_q <= '0;
						unique case (cmd_item.cmd) inside
							CMD_APPEND: begin
								state_q <= S_DONE;
								if (full) begin
									res_q <= '{status: ST_FULL, default: '0};
								end else begin
									res_q   <= '{status: ST_OK, default: '0};
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_REMOVE, CMD_FIND_JOB, CMD_FIND_PROC, CMD_SET_STATE: begin
								res_q   <= '{status: ST_MISS, default: '0};
								state_q <= (count_q != '0) ? S_SEARCH : S_DONE;
							end
							default: begin
								res_q   <= '{status: ST_MISS, default: '0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						res_q <= '{status: ST_OK, found: 1'b1,
							out_job_id: hit_entry.job,
							out_proc_id: hit_entry.proc_id,
							out_state: hit_entry.state};
						if ((cmd_q.cmd == CMD_REMOVE) && !last) begin
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_DONE;
						end
						if ((cmd_q.cmd == CMD_REMOVE) && last) begin
							count_q <= count_q - CNT_W'(1);
						end
					end else if (last) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SHIFT: begin
					if (shift_last) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done_o.done = (state_q == S_DONE);
	assign done_o.res  = res_q;

endmodule

`default_nettype wire

### rtl/process_job_table.sv
// An append, or a refused append, goes from accept to the S_DONE state and then
// into the output register. A search walks the table from position 0 until it
// hits or passes the last entry; a removal that hits before the last entry first
// compacts the entries behind it into the gap. One transaction at a time, with
// the single table read port walking one entry per cycle.
// Reset clears the entry count and control only; table contents are not cleared.
// ----------------------------------------------------------------------------
// process_job_table: ordered job table
// Append, remove with compaction, lookup by job or process id, set state.
// ----------------------------------------------------------------------------
`default_nettype none

module process_job_table (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cmd_valid,
	output logic                     cmd_stall,
	input  wire pjt_pkg::cmd_item_t  cmd_item,
	output logic                     res_valid,
	input  wire                      res_stall,
	output pjt_pkg::res_item_t       res_item
);
	import pjt_pkg::*;

	mem_req_t  req;
	entry_t    rd;
	done_t     done;
	logic      res_take;
	logic      res_valid_q;
	res_item_t res_item_q;

	// table storage: single write, single registered read
	pjt_store u_store (
		.clk (clk),
		.req (req),
		.rd  (rd)
	);

	// sequencer with the shared key comparator
	pjt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_take  (res_take),
		.done_o    (done),
		.req       (req),
		.rd        (rd)
	);

	// output register: the finished result moves here when the slot is free
	assign res_take = done.done && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q <= done.done;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			res_item_q <= done.res;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// a new transaction is only taken once the previous one has been handed off
	a_no_accept_while_done: assert property (@(posedge clk) disable iff (!arst_n)
		done.done |-> cmd_stall)
		else $error("command accepted while a result is pending");

	// a handed-off result shows up on the output
	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> res_valid)
		else $error("result taken but not presented");

	// a found result always carries ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.found |-> res_item.status == ST_OK)
		else $error("found result without ok status");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.status == ST_FULL || res_item.status == ST_MISS)
		|-> !res_item.found && res_item.out_job_id == '0 && res_item.out_state == '0)
		else $error("failed result carries entry data");

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ordered job table
// Drives append, remove, lookup and set-state transactions with random gaps
// and back-pressure, predicts every result from a local table copy and checks
// each returned transaction field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pjt_pkg::*;

	// codes five to seven have no meaning; the block answers them as a miss
	localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

	localparam int unsigned RANDOM_ITEMS = 1000;
	localparam int unsigned MAX_GAP      = 17;
	localparam int unsigned HOLD_AT      = 300;  // results seen before the long hold
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TAIL_CYCLES  = 48;   // more than a full walk plus compaction

	typedef struct {
		cmd_item_t item;
		bit        drain;  // wait for all results before offering this one
	} pend_item_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	process_job_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Job table predictor: its own copy of the ordered table
	// ------------------------------------------------------------------------
	entry_t      job_tab [ENTRIES];
	int unsigned job_cnt = 0;

	function automatic int first_job(logic [15:0] job);
		for (int i = 0; i < int'(job_cnt); i++) begin
			if (job_tab[i].job == job) return i;
		end
		return -1;
	endfunction

	function automatic int first_proc(logic [21:0] pid);
		for (int i = 0; i < int'(job_cnt); i++) begin
			if (job_tab[i].proc_id == pid) return i;
		end
		return -1;
	endfunction

	function automatic res_item_t hit_result(int idx);
		res_item_t r;
		r.status      = ST_OK;
		r.found       = 1'b1;
		r.out_job_id  = job_tab[idx].job;
		r.out_proc_id = job_tab[idx].proc_id;
		r.out_state   = job_tab[idx].state;
		return r;
	endfunction

	// Applies one command to the table copy and returns what the block must answer.
	function automatic res_item_t table_answer(cmd_item_t c);
		res_item_t r;
		int        hit;
		r = '0;
		r.status = ST_MISS;
		case (c.cmd)
			CMD_APPEND: begin
				if (job_cnt >= ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					job_tab[job_cnt] = '{job: c.job_id, proc_id: c.proc_id, state: c.new_state};
					job_cnt++;
					r.status = ST_OK;
				end
			end
			CMD_REMOVE: begin
				hit = first_proc(c.proc_id);
				if (hit >= 0) begin
					r = hit_result(hit);
					// close the gap, keeping order
					for (int i = hit; i + 1 < int'(job_cnt); i++) job_tab[i] = job_tab[i + 1];
					job_cnt--;
				end
			end
			CMD_FIND_JOB: begin
				hit = first_job(c.job_id);
				if (hit >= 0) r = hit_result(hit);
			end
			CMD_FIND_PROC: begin
				hit = first_proc(c.proc_id);
				if (hit >= 0) r = hit_result(hit);
			end
			CMD_SET_STATE: begin
				hit = first_job(c.job_id);
				if (hit >= 0) begin
					job_tab[hit].state = c.new_state;
					r = hit_result(hit);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------------
	pend_item_t  pending_q[$];
	res_item_t   answer_q[$];
	int unsigned errors = 0;

	// small key pools per phase so lookups and removals mostly hit,
	// and duplicate keys are common
	logic [15:0] job_pool  [8];
	logic [21:0] proc_pool [8];

	function automatic cmd_item_t mk_cmd(logic [2:0] cmd, logic [15:0] job,
			logic [21:0] pid, logic [7:0] st);
		cmd_item_t c;
		c.cmd       = cmd;
		c.job_id    = job;
		c.proc_id   = pid;
		c.new_state = st;
		return c;
	endfunction

	task automatic refresh_pools();
		int unsigned roll;
		for (int i = 0; i < 8; i++) begin
			roll = $urandom_range(0, 9);
			job_pool[i]  = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
			roll = $urandom_range(0, 9);
			proc_pool[i] = (roll == 0) ? 22'h0 : (roll == 1) ? 22'h3FFFFF : 22'($urandom);
		end
	endtask

	function automatic cmd_item_t rand_cmd(int unsigned append_pct);
		cmd_item_t   c;
		int unsigned roll;
		c.job_id    = ($urandom_range(0, 3) != 0) ? job_pool[$urandom_range(0, 7)]
		                                           : 16'($urandom);
		c.proc_id   = ($urandom_range(0, 3) != 0) ? proc_pool[$urandom_range(0, 7)]
		                                           : 22'($urandom);
		c.new_state = 8'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < append_pct) begin
			c.cmd = CMD_APPEND;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 30)      c.cmd = CMD_REMOVE;
			else if (roll < 55) c.cmd = CMD_FIND_JOB;
			else if (roll < 80) c.cmd = CMD_FIND_PROC;
			else if (roll < 95) c.cmd = CMD_SET_STATE;
			else                c.cmd = 3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
		end
		return c;
	endfunction

	task automatic add_item(cmd_item_t c, bit drain);
		pend_item_t p;
		p.item  = c;
		p.drain = drain;
		pending_q.push_back(p);
	endtask

	// ------------------------------------------------------------------------
	// Command driver: changes inputs on the falling edge only
	// ------------------------------------------------------------------------
	logic        cmd_taken = 1'b0;  // registered at the rising edge
	logic        res_taken = 1'b0;
	int unsigned snd_gap = 0;
	bit          snd_burst = 1'b0;
	pend_item_t  drv_next;

	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (cmd_valid && !cmd_taken) begin
			// stalled: keep the transaction as it is
		end else if (snd_gap != 0) begin
			snd_gap--;
			cmd_valid <= 1'b0;
		end else if (pending_q.size() != 0 && !(pending_q[0].drain && answer_q.size() != 0)) begin
			drv_next = pending_q.pop_front();
			cmd_item  <= drv_next.item;
			cmd_valid <= 1'b1;
			// occasional switch between back-to-back stretches and random gaps
			if ($urandom_range(0, 19) == 0) snd_burst = !snd_burst;
			snd_gap = snd_burst ? 0 : $urandom_range(0, MAX_GAP);
		end else begin
			cmd_valid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: random stall per transaction plus one long hold
	// ------------------------------------------------------------------------
	int unsigned results_seen = 0;
	int unsigned rcv_wait = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	bit          rcv_burst = 1'b0;

	always @(negedge clk) begin
		if (!hold_done && results_seen >= HOLD_AT) begin
			// long hold: the block fills up and must stall the command side
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (res_taken) begin
			if ($urandom_range(0, 19) == 0) rcv_burst = !rcv_burst;
			rcv_wait = rcv_burst ? 0 : $urandom_range(0, MAX_GAP);
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (rcv_wait != 0) begin
			rcv_wait--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: samples both channels on the rising edge
	// ------------------------------------------------------------------------
	task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
		errors++;
	endtask

	task automatic check_result(res_item_t exp_r, res_item_t act_r);
		if (act_r.status !== exp_r.status)
			report_field("status", exp_r.status, act_r.status);
		if (act_r.found !== exp_r.found)
			report_field("found", exp_r.found, act_r.found);
		if (act_r.out_job_id !== exp_r.out_job_id)
			report_field("out_job_id", exp_r.out_job_id, act_r.out_job_id);
		if (act_r.out_proc_id !== exp_r.out_proc_id)
			report_field("out_proc_id", exp_r.out_proc_id, act_r.out_proc_id);
		if (act_r.out_state !== exp_r.out_state)
			report_field("out_state", exp_r.out_state, act_r.out_state);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result transaction, expected none, actual %p",
						$time, res_item);
					errors++;
				end else begin
					check_result(answer_q.pop_front(), res_item);
				end
				results_seen++;
			end
			if (cmd_valid && !cmd_stall) answer_q.push_back(table_answer(cmd_item));
		end
		cmd_taken <= arst_n && cmd_valid && !cmd_stall;
		res_taken <= arst_n && res_valid && !res_stall;
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned total;
		int unsigned bias;
		int unsigned len;
		int unsigned phase;

		// directed: empty table, extremes, duplicates, head and tail removal
		add_item(mk_cmd(CMD_FIND_JOB,  16'h0000, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_REMOVE,    16'h0000, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_FIND_PROC, 16'hFFFF, 22'h3FFFFF, 8'hFF), 1'b0);
		add_item(mk_cmd(CMD_SET_STATE, 16'hFFFF, 22'h3FFFFF, 8'hFF), 1'b0);
		add_item(mk_cmd(CMD_APPEND,    16'h0000, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_APPEND,    16'hFFFF, 22'h3FFFFF, 8'hFF), 1'b0);
		add_item(mk_cmd(CMD_APPEND,    16'h1234, 22'h5,      8'h07), 1'b0);
		add_item(mk_cmd(CMD_APPEND,    16'hFFFF, 22'h2,      8'h03), 1'b0);  // duplicate job
		add_item(mk_cmd(CMD_FIND_JOB,  16'hFFFF, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_FIND_PROC, 16'h0000, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_FIND_PROC, 16'h0000, 22'h3FFFFF, 8'h00), 1'b0);
		add_item(mk_cmd(CMD_SET_STATE, 16'hFFFF, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_SET_STATE, 16'h0000, 22'h3FFFFF, 8'hFF), 1'b0);
		add_item(mk_cmd(CMD_REMOVE,    16'hFFFF, 22'h0,      8'h00), 1'b0);  // head entry
		add_item(mk_cmd(CMD_FIND_JOB,  16'h0000, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_REMOVE,    16'h0000, 22'h2,      8'h00), 1'b0);  // tail entry
		add_item(mk_cmd(CMD_REMOVE,    16'h0000, 22'h9,      8'h00), 1'b0);  // miss
		add_item(mk_cmd(CMD_RSVD_FIRST, 16'hFFFF, 22'h3FFFFF, 8'hFF), 1'b0);
		add_item(mk_cmd(CMD_RSVD_LAST,  16'hFFFF, 22'h3FFFFF, 8'hFF), 1'b0);
		add_item(mk_cmd(CMD_FIND_JOB,  16'h1234, 22'h0,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_REMOVE,    16'h0000, 22'h5,      8'h00), 1'b0);
		add_item(mk_cmd(CMD_REMOVE,    16'h0000, 22'h3FFFFF, 8'h00), 1'b0);  // last one left
		add_item(mk_cmd(CMD_FIND_PROC, 16'h0000, 22'h3FFFFF, 8'h00), 1'b0);

		// random phases: fill, mixed and drain biases; the first one fills the
		// table to full, every third phase starts after the block has gone quiet
		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			refresh_pools();
			case ($urandom_range(0, 2))
				0:       bias = 80;
				1:       bias = 45;
				default: bias = 15;
			endcase
			if (phase == 0) bias = 85;
			len = $urandom_range(40, 120);
			for (int k = 0; k < int'(len); k++) begin
				add_item(rand_cmd(bias), k == 0 && (phase % 3) == 0);
			end
			total += len;
			phase++;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// everything sent and answered, then let any stray result show up
		while (pending_q.size() != 0 || cmd_valid || answer_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/pjt_pkg.sv
rtl/pjt_store.sv
rtl/pjt_ctrl.sv
rtl/process_job_table.sv
dv/tb.sv
